@@ hdl/boids_flock_steering_assert.svh @@
// assertion macros for the boids steering block
`ifndef BOIDS_FLOCK_STEERING_ASSERT_SVH
`define BOIDS_FLOCK_STEERING_ASSERT_SVH

// checked outside reset only
`define BFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define BFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bfs_pkg.sv @@
// shared types, constants and helpers of the boids steering block
package bfs_pkg;

  localparam int MAX_NEIGHBORS = 1024;
  localparam int COUNT_CAP     = (MAX_NEIGHBORS < 2047) ? MAX_NEIGHBORS : 2047;

  localparam int CNT_W  = 11;
  localparam int ACC_W  = 44;
  localparam int TERM_W = 45;
  localparam int PROD_W = 53;
  localparam int DVSR_W = 21;
  localparam int QUO_W  = 54;
  localparam int TOT_W  = 48;

  localparam logic [9:0] WEIGHT_DIV = 10'd1000;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_FISH  = 2'd1;
  localparam logic [1:0] REQ_SHARK = 2'd2;

  localparam logic [2:0] CFG_VISION_RSQ = 3'd0;
  localparam logic [2:0] CFG_SEP_RSQ    = 3'd1;
  localparam logic [2:0] CFG_ALIGN_W    = 3'd2;
  localparam logic [2:0] CFG_COHES_W    = 3'd3;
  localparam logic [2:0] CFG_SEP_W      = 3'd4;
  localparam logic [2:0] CFG_SHARK_W    = 3'd5;

  localparam logic [2:0] LAST_TERM = 3'd7;

  localparam logic signed [45:0] ACC_HI = 46'sd8796093022207;
  localparam logic signed [45:0] ACC_LO = -46'sd8796093022208;
  localparam logic signed [TOT_W-1:0] V_HI = TOT_W'(64'sd2147483647);
  localparam logic signed [TOT_W-1:0] V_LO = TOT_W'(-64'sd2147483648);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_SQR, ST_ACC, ST_PREP_A, ST_PREP_B, ST_DIV, ST_ADD, ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic       capture;
    logic       diff;
    logic       square;
    logic       accum;
    logic       tot_init;
    logic       prep_a;
    logic       div_start;
    logic       term_add;
    logic       out_load;
    logic [2:0] term;
  } bfs_cmd_t;

  typedef struct packed {
    logic last;
    logic div_busy;
    logic out_free;
  } bfs_status_t;

  function automatic logic signed [ACC_W-1:0] sat_add44(
    input logic signed [ACC_W-1:0]  a,
    input logic signed [TERM_W-1:0] b
  );
    logic signed [45:0] s;
    s = {{2{a[ACC_W-1]}}, a} + {b[TERM_W-1], b};
    if (s > ACC_HI) s = ACC_HI;
    else if (s < ACC_LO) s = ACC_LO;
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [TOT_W-1:0] v);
    logic signed [TOT_W-1:0] r;
    r = v;
    if (v > V_HI) r = V_HI;
    else if (v < V_LO) r = V_LO;
    return r[31:0];
  endfunction

endpackage

@@ hdl/bfs_div.sv @@
// sequential restoring divider, signed dividend over unsigned divisor, truncating
module bfs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [bfs_pkg::PROD_W-1:0] dividend,
  input  logic        [bfs_pkg::DVSR_W-1:0] divisor,
  output logic                              busy,
  output logic signed [bfs_pkg::QUO_W-1:0]  quotient
);
  import bfs_pkg::*;

  localparam int CNT_BITS = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] quo;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dvsr;
  logic [CNT_BITS-1:0] cnt;
  logic neg;
  logic [DVSR_W:0] rem_sh;
  logic [DVSR_W:0] rem_sub;

  assign rem_sh  = {rem, quo[PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(PROD_W);
      rem  <= '0;
      dvsr <= divisor;
      neg  <= dividend[PROD_W-1];
      quo  <= dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
    end else if (busy) begin
      // one quotient bit per cycle
      if (rem_sh >= {1'b0, dvsr}) begin
        rem <= rem_sub[DVSR_W-1:0];
        quo <= {quo[PROD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DVSR_W-1:0];
        quo <= {quo[PROD_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) busy <= 1'b0;
    end
  end

  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

@@ hdl/bfs_ctrl.sv @@
// controller state machine of the boids steering block
module bfs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  bfs_pkg::bfs_status_t status,
  output bfs_pkg::bfs_cmd_t    cmd
);
  import bfs_pkg::*;

  ctrl_state_t state, state_next;
  logic [2:0] term, term_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      term  <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

  always_comb begin
    state_next = state;
    term_next  = term;
    cmd        = '0;
    cmd.term   = term;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_SQR;
      end
      ST_SQR: begin
        cmd.square = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        if (status.last) begin
          term_next  = '0;
          state_next = ST_PREP_A;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PREP_A: begin
        // totals start from the own velocity after the last accumulation
        cmd.tot_init = (term == '0);
        cmd.prep_a   = 1'b1;
        state_next   = ST_PREP_B;
      end
      ST_PREP_B: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (!status.div_busy) state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.term_add = 1'b1;
        if (term == LAST_TERM) begin
          state_next = ST_OUT;
        end else begin
          term_next  = term + 1'b1;
          state_next = ST_PREP_A;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/bfs_dp.sv @@
// datapath: agent state, radius tests, saturating sums, steering terms, output register
module bfs_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [30:0]          cfg_wdata,
  input  logic [1:0]           s_tuser,
  input  logic [127:0]         s_tdata,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [79:0]          m_tdata,
  input  bfs_pkg::bfs_cmd_t    cmd,
  output bfs_pkg::bfs_status_t status
);
  import bfs_pkg::*;

  logic [30:0] vis_rsq, sep_rsq;
  logic signed [7:0] aw, cw, sw, kw;

  logic [1:0] in_kind;
  logic in_last;
  logic signed [31:0] in_px, in_py, in_vx, in_vy;
  logic signed [31:0] own_x, own_y, own_vx, own_vy;

  logic signed [ACC_W-1:0] sum_vx, sum_vy, sum_px, sum_py;
  logic signed [ACC_W-1:0] sep_x, sep_y, shk_x, shk_y;
  logic [CNT_W-1:0] seen_cnt;

  logic signed [32:0] dx, dy, dx_c, dy_c, mx_c, my_c;
  logic far;
  logic [29:0] mag_x, mag_y;
  logic [59:0] sq_x, sq_y;

  logic [60:0] dsq;
  logic in_vis, in_sep;
  logic signed [TERM_W-1:0] ofs_x, ofs_y;

  logic signed [TERM_W-1:0] t_reg, t_next;
  logic signed [7:0] w_reg, w_next;
  logic signed [ACC_W-1:0] sel_sum;
  logic signed [ACC_W-1:0] n_own;
  logic signed [PROD_W-1:0] dividend;
  logic [DVSR_W-1:0] divisor;
  logic div_busy;
  logic signed [QUO_W-1:0] quotient;
  logic signed [TOT_W-1:0] tot_x, tot_y, term_val;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vis_rsq <= '0;
      sep_rsq <= '0;
      aw <= '0;
      cw <= '0;
      sw <= '0;
      kw <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_VISION_RSQ: vis_rsq <= cfg_wdata;
        CFG_SEP_RSQ:    sep_rsq <= cfg_wdata;
        CFG_ALIGN_W:    aw <= cfg_wdata[7:0];
        CFG_COHES_W:    cw <= cfg_wdata[7:0];
        CFG_SEP_W:      sw <= cfg_wdata[7:0];
        CFG_SHARK_W:    kw <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // offset to the agent and its magnitude, any axis at 2^30 or more is out of every radius
  assign dx_c = {in_px[31], in_px} - {own_x[31], own_x};
  assign dy_c = {in_py[31], in_py} - {own_y[31], own_y};
  assign mx_c = dx_c[32] ? -dx_c : dx_c;
  assign my_c = dy_c[32] ? -dy_c : dy_c;

  assign dsq    = {1'b0, sq_x} + {1'b0, sq_y};
  assign in_vis = !far && (dsq <= {2'b00, vis_rsq, 28'd0});
  assign in_sep = !far && (dsq <= {2'b00, sep_rsq, 28'd0});
  assign ofs_x  = TERM_W'(-dx);
  assign ofs_y  = TERM_W'(-dy);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_kind <= s_tuser;
      in_last <= s_tlast;
      in_px   <= s_tdata[31:0];
      in_py   <= s_tdata[63:32];
      in_vx   <= s_tdata[95:64];
      in_vy   <= s_tdata[127:96];
    end
    if (cmd.diff) begin
      dx    <= dx_c;
      dy    <= dy_c;
      far   <= (|mx_c[32:30]) | (|my_c[32:30]);
      mag_x <= mx_c[29:0];
      mag_y <= my_c[29:0];
    end
    if (cmd.square) begin
      sq_x <= mag_x * mag_x;
      sq_y <= mag_y * mag_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_x <= '0;
      own_y <= '0;
      own_vx <= '0;
      own_vy <= '0;
      sum_vx <= '0;
      sum_vy <= '0;
      sum_px <= '0;
      sum_py <= '0;
      sep_x <= '0;
      sep_y <= '0;
      shk_x <= '0;
      shk_y <= '0;
      seen_cnt <= '0;
    end else if (cmd.accum) begin
      unique case (in_kind)
        REQ_LOAD: begin
          own_x <= in_px;
          own_y <= in_py;
          own_vx <= in_vx;
          own_vy <= in_vy;
          sum_vx <= '0;
          sum_vy <= '0;
          sum_px <= '0;
          sum_py <= '0;
          sep_x <= '0;
          sep_y <= '0;
          shk_x <= '0;
          shk_y <= '0;
          seen_cnt <= '0;
        end
        REQ_FISH: begin
          if (in_vis && (seen_cnt < CNT_W'(COUNT_CAP))) begin
            sum_vx <= sat_add44(sum_vx, TERM_W'(in_vx));
            sum_vy <= sat_add44(sum_vy, TERM_W'(in_vy));
            sum_px <= sat_add44(sum_px, TERM_W'(in_px));
            sum_py <= sat_add44(sum_py, TERM_W'(in_py));
            seen_cnt <= seen_cnt + 1'b1;
          end
          if (in_sep) begin
            sep_x <= sat_add44(sep_x, ofs_x);
            sep_y <= sat_add44(sep_y, ofs_y);
          end
        end
        REQ_SHARK: begin
          if (in_vis) begin
            shk_x <= sat_add44(shk_x, ofs_x);
            shk_y <= sat_add44(shk_y, ofs_y);
          end
        end
        default: ;
      endcase
    end
  end

  // term order: align x/y, cohesion x/y, separation x/y, shark x/y
  always_comb begin
    unique case (cmd.term)
      3'd0: sel_sum = sum_vx;
      3'd1: sel_sum = sum_vy;
      3'd2: sel_sum = sum_px;
      3'd3: sel_sum = sum_py;
      3'd4: sel_sum = sep_x;
      3'd5: sel_sum = sep_y;
      3'd6: sel_sum = shk_x;
      default: sel_sum = shk_y;
    endcase
    unique case (cmd.term[2:1])
      2'd0: w_next = aw;
      2'd1: w_next = cw;
      2'd2: w_next = sw;
      default: w_next = kw;
    endcase
  end

  assign n_own  = $signed({1'b0, seen_cnt}) * (cmd.term[0] ? own_y : own_x);
  assign t_next = {sel_sum[ACC_W-1], sel_sum} -
                  ((cmd.term[2:1] == 2'd1) ? {n_own[ACC_W-1], n_own} : TERM_W'(0));

  assign dividend = t_reg * w_reg;
  assign divisor  = cmd.term[2] ? DVSR_W'(WEIGHT_DIV) : seen_cnt * WEIGHT_DIV;

  always_ff @(posedge clk) begin
    if (cmd.prep_a) begin
      t_reg <= t_next;
      w_reg <= w_next;
    end
  end

  bfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // averaged terms drop out when no fish was seen
  assign term_val = (!cmd.term[2] && (seen_cnt == '0)) ? TOT_W'(0) : quotient[TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.tot_init) begin
      tot_x <= TOT_W'(own_vx);
      tot_y <= TOT_W'(own_vy);
    end else if (cmd.term_add) begin
      if (cmd.term[0]) tot_y <= tot_y + term_val;
      else tot_x <= tot_x + term_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= {5'd0, seen_cnt, sat32(tot_y), sat32(tot_x)};
  end

  assign status.last     = in_last;
  assign status.div_busy = div_busy;
  assign status.out_free = !m_tvalid || m_tready;

endmodule

@@ hdl/boids_flock_steering.sv @@
// top level of the boids steering block
//
// channel   direction  content
// s_*       in         tdata pos_x, pos_y, vel_x, vel_y; tuser req_type; tlast last
// m_*       out        tdata new_vel_x, new_vel_y, visible_count
// cfg_*     in         register writes, index 0..5
//
// an item passes the steps accept, offset, squaring, compare and accumulate.
// a last item then runs eight divisions on one shared divider of 53 steps
// each before the result enters the output register.
// reset is synchronous and clears configuration registers, agent state and sums.
// a result waiting in the output register stalls only the next result.
module boids_flock_steering (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // pos_x, pos_y, vel_x, vel_y
  input  logic [1:0]   s_tuser,   // req_type
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata    // new_vel_x, new_vel_y, visible_count, zero pad
);
  import bfs_pkg::*;

  bfs_cmd_t    cmd;
  bfs_status_t status;

  bfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bfs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

@@ hdl/bfs_checker.sv @@
// port checker of the boids steering block and its bind
`include "boids_flock_steering_assert.svh"

module bfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);
  // one item in work at a time
  `BFS_ASSERT(a_one_item, (s_tvalid && s_tready) |=> !s_tready, "input taken while busy")
  `BFS_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result lost")
  `BFS_ASSERT_ALWAYS(a_count, m_tvalid |-> (m_tdata[74:64] <= 11'd1024), "count over cap")
  // a result needs at least the accumulate step after an accepted item
  `BFS_ASSERT(a_no_early, (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid, "early result")
endmodule

bind boids_flock_steering bfs_checker u_chk (.*);
